// ===== sv/cscd_pkg.sv =====
// Package of the clock run/set controller: command and field codes, limits,
// the state snapshot and result bundles, and the binary to BCD helper.
// No dependencies.
package cscd_pkg;

	localparam int DIGITS_W = 24;
	localparam int BYTE_W   = 8;
	localparam int CMD_W    = 3;
	localparam int BRIGHT_W = 4;
	localparam int CNT_W    = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_MODE    = 3'd1,
		CMD_INC     = 3'd2,
		CMD_DEC     = 3'd3,
		CMD_REFRESH = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		FLD_MONTH  = 3'd0,
		FLD_DAY    = 3'd1,
		FLD_YEAR   = 3'd2,
		FLD_HOUR   = 3'd3,
		FLD_MINUTE = 3'd4
	} field_t;

	typedef enum logic {
		CFG_BLINK_LIMIT     = 1'b0,
		CFG_INTENSITY_START = 1'b1
	} cfg_idx_t;

	localparam logic [BRIGHT_W-1:0] MAX_BRIGHT        = 4'd14;
	localparam logic [BRIGHT_W-1:0] RESET_INTENSITY   = 4'd7;
	localparam logic [BYTE_W-1:0]   RESET_BLINK_LIMIT = 8'd100;
	localparam logic [3:0]          BLANK             = 4'hF;

	localparam logic [CNT_W-1:0] ADJ_MAX    = 7'd99;
	localparam logic [CNT_W-1:0] LIM_MONTH  = 7'd12;
	localparam logic [CNT_W-1:0] LIM_DAY    = 7'd31;
	localparam logic [CNT_W-1:0] LIM_YEAR   = 7'd99;
	localparam logic [CNT_W-1:0] LIM_HOUR   = 7'd23;
	localparam logic [CNT_W-1:0] LIM_MINUTE = 7'd59;
	localparam logic [CNT_W-1:0] NOON       = 7'd12;

	localparam logic [BYTE_W-1:0] HOUR_12H = 8'h40;
	localparam logic [BYTE_W-1:0] HOUR_PM  = 8'h60;

	// State after an event: what the display formatter needs.
	typedef struct packed {
		logic                set_mode;
		field_t              set_field;
		logic                blink_phase;
		logic                commit;
		logic [BRIGHT_W-1:0] brightness;
		logic [BYTE_W-1:0]   seconds;
		logic [BYTE_W-1:0]   minutes;
		logic [BYTE_W-1:0]   hours;
		logic [BYTE_W-1:0]   day;
		logic [BYTE_W-1:0]   month;
		logic [BYTE_W-1:0]   year;
	} view_t;

	typedef struct packed {
		logic [DIGITS_W-1:0] digits;
		logic                am_led;
		logic                pm_led;
		logic [BRIGHT_W-1:0] intensity;
		logic                commit;
		logic [BYTE_W-1:0]   commit_minutes;
		logic [BYTE_W-1:0]   commit_hours;
		logic [BYTE_W-1:0]   commit_day;
		logic [BYTE_W-1:0]   commit_month;
		logic [BYTE_W-1:0]   commit_year;
	} result_t;

	// Binary to BCD for values up to 99; tens by reciprocal multiply (205/2048).
	function automatic logic [BYTE_W-1:0] to_bcd(input logic [CNT_W-1:0] v);
		logic [14:0]      prod;
		logic [3:0]       tens;
		logic [CNT_W-1:0] units;
		prod  = {8'd0, v} * 15'd205;
		tens  = prod[14:11];
		units = v - 7'({3'd0, tens} * 7'd10);
		return {tens, units[3:0]};
	endfunction

endpackage

// ===== sv/cscd_core.sv =====
// State and next-state logic of the clock run/set controller: mode, field,
// adjust counter, brightness, blink timer and the clock bytes of seconds,
// minutes, hours, day, month and year. Depends on cscd_pkg.
module cscd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic                          cfg_idx,
	input  logic [cscd_pkg::BYTE_W-1:0]   cfg_wdata,
	input  logic                          step,
	input  logic [cscd_pkg::CMD_W-1:0]    cmd,
	input  logic [cscd_pkg::BYTE_W-1:0]   rtc_seconds,
	input  logic [cscd_pkg::BYTE_W-1:0]   rtc_minutes,
	input  logic [cscd_pkg::BYTE_W-1:0]   rtc_hours,
	input  logic [cscd_pkg::BYTE_W-1:0]   rtc_day,
	input  logic [cscd_pkg::BYTE_W-1:0]   rtc_month_in,
	input  logic [cscd_pkg::BYTE_W-1:0]   rtc_year_in,
	output cscd_pkg::view_t               nxt_view
);
	import cscd_pkg::*;

	logic                set_mode_q, set_mode_d;
	field_t              set_field_q, set_field_d;
	logic [CNT_W-1:0]    adjust_count_q, adjust_count_d;
	logic [BRIGHT_W-1:0] brightness_q, brightness_d;
	logic [BYTE_W-1:0]   blink_ticks_q, blink_ticks_d;
	logic                blink_phase_q, blink_phase_d;
	logic [BYTE_W-1:0]   blink_limit_q;
	logic [BYTE_W-1:0]   sec_q, min_q, hr_q, day_q, mon_q, yr_q;
	logic [BYTE_W-1:0]   sec_d, min_d, hr_d, day_d, mon_d, yr_d;
	logic                commit_d;
	logic [BYTE_W:0]     tick_sum;
	logic [CNT_W-1:0]    clamped;
	logic [CNT_W-1:0]    adj_cmd;
	logic [BRIGHT_W-1:0] cfg_bright;

	assign cfg_bright = (cfg_wdata[BRIGHT_W-1:0] > MAX_BRIGHT) ? MAX_BRIGHT
	                                                          : cfg_wdata[BRIGHT_W-1:0];

	always_comb begin
		set_mode_d    = set_mode_q;
		set_field_d   = set_field_q;
		adj_cmd       = adjust_count_q;
		brightness_d  = brightness_q;
		blink_ticks_d = blink_ticks_q;
		blink_phase_d = blink_phase_q;
		sec_d         = sec_q;
		min_d         = min_q;
		hr_d          = hr_q;
		day_d         = day_q;
		mon_d         = mon_q;
		yr_d          = yr_q;
		commit_d      = 1'b0;
		tick_sum      = {1'b0, blink_ticks_q} + 9'd1;
		clamped       = '0;

		case (cmd_t'(cmd))
			CMD_TICK: begin
				if (tick_sum > {1'b0, blink_limit_q}) begin
					blink_ticks_d = '0;
					blink_phase_d = ~blink_phase_q;
				end else begin
					blink_ticks_d = tick_sum[BYTE_W-1:0];
				end
			end
			CMD_MODE: begin
				if (!set_mode_q) begin
					set_mode_d = 1'b1;
				end else if (set_field_q != FLD_MINUTE) begin
					set_field_d = field_t'(set_field_q + 3'd1);
					adj_cmd     = '0;
				end else begin
					set_mode_d  = 1'b0;
					set_field_d = FLD_MONTH;
					adj_cmd     = '0;
					commit_d    = 1'b1;
				end
			end
			CMD_INC: begin
				if (!set_mode_q) begin
					if (brightness_q < MAX_BRIGHT) brightness_d = brightness_q + 4'd1;
				end else if (adjust_count_q < ADJ_MAX) begin
					adj_cmd = adjust_count_q + 7'd1;
				end
			end
			CMD_DEC: begin
				if (!set_mode_q) begin
					if (brightness_q != '0) brightness_d = brightness_q - 4'd1;
				end else if (adjust_count_q != '0) begin
					adj_cmd = adjust_count_q - 7'd1;
				end
			end
			CMD_REFRESH: begin
				if (!set_mode_q) begin
					sec_d = rtc_seconds;
					min_d = rtc_minutes;
					hr_d  = rtc_hours;
					day_d = rtc_day;
					mon_d = rtc_month_in;
					yr_d  = rtc_year_in;
				end
			end
			default: begin
			end
		endcase

		adjust_count_d = adj_cmd;
		// In set mode clamp the counter to the field and store it as BCD.
		if (set_mode_d) begin
			case (set_field_d)
				FLD_MONTH: begin
					clamped = (adj_cmd > LIM_MONTH) ? LIM_MONTH : adj_cmd;
					mon_d   = to_bcd(clamped) & 8'h1F;
				end
				FLD_DAY: begin
					clamped = (adj_cmd > LIM_DAY) ? LIM_DAY : adj_cmd;
					day_d   = to_bcd(clamped) & 8'h3F;
				end
				FLD_YEAR: begin
					clamped = (adj_cmd > LIM_YEAR) ? LIM_YEAR : adj_cmd;
					yr_d    = to_bcd(clamped);
				end
				FLD_HOUR: begin
					clamped = (adj_cmd > LIM_HOUR) ? LIM_HOUR : adj_cmd;
					if (clamped <= NOON) hr_d = (to_bcd(clamped) & 8'h1F) | HOUR_12H;
					else hr_d = (to_bcd(clamped - NOON) & 8'h1F) | HOUR_PM;
				end
				default: begin
					clamped = (adj_cmd > LIM_MINUTE) ? LIM_MINUTE : adj_cmd;
					min_d   = to_bcd(clamped) & 8'h7F;
				end
			endcase
			adjust_count_d = clamped;
			sec_d          = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_mode_q     <= 1'b0;
			set_field_q    <= FLD_MONTH;
			adjust_count_q <= '0;
			brightness_q   <= RESET_INTENSITY;
			blink_ticks_q  <= '0;
			blink_phase_q  <= 1'b0;
			blink_limit_q  <= RESET_BLINK_LIMIT;
			sec_q          <= '0;
			min_q          <= '0;
			hr_q           <= '0;
			day_q          <= '0;
			mon_q          <= '0;
			yr_q           <= '0;
		end else if (cfg_wen) begin
			if (cfg_idx_t'(cfg_idx) == CFG_BLINK_LIMIT) blink_limit_q <= cfg_wdata;
			else brightness_q <= cfg_bright;
		end else if (step) begin
			set_mode_q     <= set_mode_d;
			set_field_q    <= set_field_d;
			adjust_count_q <= adjust_count_d;
			brightness_q   <= brightness_d;
			blink_ticks_q  <= blink_ticks_d;
			blink_phase_q  <= blink_phase_d;
			sec_q          <= sec_d;
			min_q          <= min_d;
			hr_q           <= hr_d;
			day_q          <= day_d;
			mon_q          <= mon_d;
			yr_q           <= yr_d;
		end
	end

	always_comb begin
		nxt_view.set_mode    = set_mode_d;
		nxt_view.set_field   = set_field_d;
		nxt_view.blink_phase = blink_phase_d;
		nxt_view.commit      = commit_d;
		nxt_view.brightness  = brightness_d;
		nxt_view.seconds     = sec_d;
		nxt_view.minutes     = min_d;
		nxt_view.hours       = hr_d;
		nxt_view.day         = day_d;
		nxt_view.month       = mon_d;
		nxt_view.year        = yr_d;
	end

endmodule

// ===== sv/cscd_view.sv =====
// Display formatter of the clock run/set controller: digits, lamps and the
// commit bytes from the state after an event. Depends on cscd_pkg.
module cscd_view (
	input  cscd_pkg::view_t   v,
	input  logic              show_date,
	output cscd_pkg::result_t r
);
	import cscd_pkg::*;

	logic bl;
	logic date_view;
	logic pm;

	function automatic logic [7:0] pair(input logic [3:0] lo, input logic [3:0] hi,
	                                    input logic blank);
		return blank ? {BLANK, BLANK} : {hi, lo};
	endfunction

	always_comb begin
		bl = v.blink_phase & v.set_mode;
		if (v.set_mode) begin
			date_view = (v.set_field == FLD_MONTH) || (v.set_field == FLD_DAY)
			         || (v.set_field == FLD_YEAR);
			pm        = ~date_view;
		end else begin
			date_view = show_date;
			pm        = v.hours[5];
		end

		if (date_view) begin
			r.digits = {pair(v.month[3:0], {3'd0, v.month[4]}, bl && v.set_field == FLD_MONTH),
			            pair(v.day[3:0], {2'd0, v.day[5:4]}, bl && v.set_field == FLD_DAY),
			            pair(v.year[3:0], v.year[7:4], bl && v.set_field == FLD_YEAR)};
		end else begin
			r.digits = {pair(v.hours[3:0], {3'd0, v.hours[4]}, bl && v.set_field == FLD_HOUR),
			            pair(v.minutes[3:0], {1'b0, v.minutes[6:4]},
			                 bl && v.set_field == FLD_MINUTE),
			            pair(v.seconds[3:0], {1'b0, v.seconds[6:4]}, 1'b0)};
		end

		r.am_led         = ~pm;
		r.pm_led         = pm;
		r.intensity      = v.brightness;
		r.commit         = v.commit;
		r.commit_minutes = v.commit ? v.minutes : '0;
		r.commit_hours   = v.commit ? v.hours   : '0;
		r.commit_day     = v.commit ? v.day     : '0;
		r.commit_month   = v.commit ? v.month   : '0;
		r.commit_year    = v.commit ? v.year    : '0;
	end

endmodule

// ===== sv/clock_set_display_controller.sv =====
// Run/set controller of a BCD clock with a six-digit display.
// A result beat appears the cycle after its event beat is accepted.
// Throughput: one event per cycle; the result register is the only stage,
// so a new event is taken whenever that register is empty or being drained.
// Reset (arst_n low): run mode, month field, brightness 7, blink limit 100,
// blink timer and all clock bytes cleared, no result pending.
// Depends on cscd_pkg, cscd_core and cscd_view.
module clock_set_display_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes: the user must issue them only while idle; not enforced
	input  logic                               cfg_wen,
	input  logic                               cfg_idx,
	input  logic [cscd_pkg::BYTE_W-1:0]        cfg_wdata,
	// event channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cscd_pkg::CMD_W-1:0]         cmd,
	input  logic                               show_date,
	input  logic [cscd_pkg::BYTE_W-1:0]        rtc_seconds,
	input  logic [cscd_pkg::BYTE_W-1:0]        rtc_minutes,
	input  logic [cscd_pkg::BYTE_W-1:0]        rtc_hours,
	input  logic [cscd_pkg::BYTE_W-1:0]        rtc_day,
	input  logic [cscd_pkg::BYTE_W-1:0]        rtc_month_in,
	input  logic [cscd_pkg::BYTE_W-1:0]        rtc_year_in,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cscd_pkg::DIGITS_W-1:0]      digits,
	output logic                               am_led,
	output logic                               pm_led,
	output logic [cscd_pkg::BRIGHT_W-1:0]      intensity,
	output logic                               commit,
	output logic [cscd_pkg::BYTE_W-1:0]        commit_minutes,
	output logic [cscd_pkg::BYTE_W-1:0]        commit_hours,
	output logic [cscd_pkg::BYTE_W-1:0]        commit_day,
	output logic [cscd_pkg::BYTE_W-1:0]        commit_month,
	output logic [cscd_pkg::BYTE_W-1:0]        commit_year
);
	import cscd_pkg::*;

	logic    step;
	view_t   nxt_view;
	result_t res_d;
	result_t res_s1;
	logic    out_valid_q;

	// Take a new event whenever the result register is free or drains now.
	assign in_ready = ~out_valid_q | out_ready;
	assign step     = in_valid & in_ready;

	// State update: the core advances its registers on each accepted beat, but a
	// config write wins; it exposes the post-event state combinationally for formatting.
	cscd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.step         (step),
		.cmd          (cmd),
		.rtc_seconds  (rtc_seconds),
		.rtc_minutes  (rtc_minutes),
		.rtc_hours    (rtc_hours),
		.rtc_day      (rtc_day),
		.rtc_month_in (rtc_month_in),
		.rtc_year_in  (rtc_year_in),
		.nxt_view     (nxt_view)
	);

	// Build digits, lamps and commit bytes from the post-event state.
	cscd_view u_view (
		.v         (nxt_view),
		.show_date (show_date),
		.r         (res_d)
	);

	// Result register: hold the beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s1 <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign digits         = res_s1.digits;
	assign am_led         = res_s1.am_led;
	assign pm_led         = res_s1.pm_led;
	assign intensity      = res_s1.intensity;
	assign commit         = res_s1.commit;
	assign commit_minutes = res_s1.commit_minutes;
	assign commit_hours   = res_s1.commit_hours;
	assign commit_day     = res_s1.commit_day;
	assign commit_month   = res_s1.commit_month;
	assign commit_year    = res_s1.commit_year;

	// An accepted event always leaves a result beat behind.
	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("accepted event left no result beat");

	// A commit always comes after the hour field: 12-hour flag set, minutes bit 7 clear.
	a_commit_hours: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && commit) |-> (commit_hours[6] && !commit_minutes[7]))
		else $error("commit hours byte lacks 12-hour flag");

	// Without a commit the write-back bytes read as zero.
	a_commit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !commit) |-> (commit_minutes == '0 && commit_hours == '0
		&& commit_day == '0 && commit_month == '0 && commit_year == '0))
		else $error("write-back bytes nonzero without commit");

	// Brightness never leaves its range.
	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (intensity <= MAX_BRIGHT))
		else $error("intensity above maximum");

	// Exactly one lamp is lit on every result.
	a_one_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (am_led != pm_led))
		else $error("lamp outputs not exclusive");

endmodule

// ===== dv/clock_set_display_controller_tb.sv =====
// Self-checking bench for the clock run/set controller: streams event beats,
// predicts every display beat with a local model of the controller, compares.
// Depends on cscd_pkg and clock_set_display_controller.
module clock_set_display_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cscd_pkg::*;

	// Command codes the block decodes to nothing; they only report the display.
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	// Slots of the clock-chip byte image.
	localparam int REG_SEC   = 0;
	localparam int REG_MIN   = 1;
	localparam int REG_HOUR  = 2;
	localparam int REG_DAY   = 3;
	localparam int REG_MONTH = 4;
	localparam int REG_YEAR  = 5;

	// Longest adjust run per set field, month through minute.
	localparam int RUN_MAX [5] = '{16, 36, 24, 30, 64};

	// Register settings for the random phases, extremes included.
	localparam int NUM_PHASES = 5;
	localparam logic [BYTE_W-1:0] PHASE_LIMIT [NUM_PHASES] = '{8'd1, 8'd255, 8'd2, 8'd37, 8'd100};
	localparam logic [BYTE_W-1:0] PHASE_START [NUM_PHASES] = '{8'd0, 8'd14, 8'd9, 8'd3, 8'd7};
	localparam int PHASE_EVENTS = 50;

	localparam int STALL_LIMIT    = 1000;
	localparam int HOLDOFF_CYCLES = 80;
	localparam int HOLDOFF_EVERY  = 260;
	localparam int MAX_REPORTS    = 40;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              show_date;
		logic [BYTE_W-1:0] seconds;
		logic [BYTE_W-1:0] minutes;
		logic [BYTE_W-1:0] hours;
		logic [BYTE_W-1:0] day;
		logic [BYTE_W-1:0] month;
		logic [BYTE_W-1:0] year;
	} clock_event_t;

	// DUT connections; every input starts at a known value.
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_wen      = 1'b0;
	logic                cfg_idx      = 1'b0;
	logic [BYTE_W-1:0]   cfg_wdata    = '0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd          = '0;
	logic                show_date    = 1'b0;
	logic [BYTE_W-1:0]   rtc_seconds  = '0;
	logic [BYTE_W-1:0]   rtc_minutes  = '0;
	logic [BYTE_W-1:0]   rtc_hours    = '0;
	logic [BYTE_W-1:0]   rtc_day      = '0;
	logic [BYTE_W-1:0]   rtc_month_in = '0;
	logic [BYTE_W-1:0]   rtc_year_in  = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [DIGITS_W-1:0] digits;
	logic                am_led;
	logic                pm_led;
	logic [BRIGHT_W-1:0] intensity;
	logic                commit;
	logic [BYTE_W-1:0]   commit_minutes;
	logic [BYTE_W-1:0]   commit_hours;
	logic [BYTE_W-1:0]   commit_day;
	logic [BYTE_W-1:0]   commit_month;
	logic [BYTE_W-1:0]   commit_year;

	clock_set_display_controller dut (.*);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Controller image kept by the bench; starts at the reset state.
	logic [BYTE_W-1:0]   blink_limit_r = RESET_BLINK_LIMIT;
	logic                set_active    = 1'b0;
	field_t              field_sel     = FLD_MONTH;
	logic [CNT_W-1:0]    adj_cnt       = '0;
	logic [BRIGHT_W-1:0] bright        = RESET_INTENSITY;
	logic [BYTE_W-1:0]   tick_cnt      = '0;
	logic                blink_on      = 1'b0;
	logic [BYTE_W-1:0]   chip_regs [6] = '{default: '0};

	clock_event_t event_q [$];      // events waiting for the driver
	result_t      predicted_q [$];  // displays owed by the block, oldest first
	clock_event_t on_wire;
	int burst_left    = 0;
	int gap_left      = 0;
	int events_queued = 0;
	int events_taken  = 0;
	int displays_seen = 0;
	int commits_seen  = 0;
	int config_writes = 0;
	int mismatches    = 0;
	int hold_left     = 0;
	int next_holdoff  = 150;
	logic [31:0] rx_cycle = '0;

	function automatic logic [BYTE_W-1:0] bcd_of(int unsigned v);
		if (v > 99) v = 99;
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// Two display digits, or both blank while the field blinks off.
	function automatic logic [7:0] digit_pair(logic [3:0] lo, logic [3:0] hi, logic off);
		return off ? {BLANK, BLANK} : {hi, lo};
	endfunction

	// Apply one event to the controller image and return the display it causes.
	function automatic result_t advance_clock(clock_event_t ev);
		result_t          r;
		logic             leaving;
		logic             blank;
		logic             date_view;
		logic [CNT_W-1:0] c;
		leaving = 1'b0;
		case (ev.cmd)
			CMD_TICK: begin
				if (tick_cnt >= blink_limit_r) begin
					tick_cnt = '0;
					blink_on = !blink_on;
				end else begin
					tick_cnt = tick_cnt + 8'd1;
				end
			end
			CMD_MODE: begin
				if (!set_active) begin
					set_active = 1'b1;
				end else if (field_sel < FLD_MINUTE) begin
					field_sel = field_t'(field_sel + 3'd1);
					adj_cnt = '0;
				end else begin
					set_active = 1'b0;
					field_sel = FLD_MONTH;
					adj_cnt = '0;
					leaving = 1'b1;
				end
			end
			CMD_INC: begin
				if (!set_active) begin
					if (bright < MAX_BRIGHT) bright = bright + 4'd1;
				end else if (adj_cnt < ADJ_MAX) begin
					adj_cnt = adj_cnt + 7'd1;
				end
			end
			CMD_DEC: begin
				if (!set_active) begin
					if (bright > 0) bright = bright - 4'd1;
				end else if (adj_cnt > 0) begin
					adj_cnt = adj_cnt - 7'd1;
				end
			end
			CMD_REFRESH: begin
				if (!set_active) begin
					chip_regs[REG_SEC]   = ev.seconds;
					chip_regs[REG_MIN]   = ev.minutes;
					chip_regs[REG_HOUR]  = ev.hours;
					chip_regs[REG_DAY]   = ev.day;
					chip_regs[REG_MONTH] = ev.month;
					chip_regs[REG_YEAR]  = ev.year;
				end
			end
			default: ;
		endcase

		// In set mode clamp the counter to the field and store it as BCD.
		if (set_active) begin
			c = adj_cnt;
			case (field_sel)
				FLD_MONTH: begin
					if (c > LIM_MONTH) c = LIM_MONTH;
					chip_regs[REG_MONTH] = bcd_of(32'(c)) & 8'h1F;
				end
				FLD_DAY: begin
					if (c > LIM_DAY) c = LIM_DAY;
					chip_regs[REG_DAY] = bcd_of(32'(c)) & 8'h3F;
				end
				FLD_YEAR: begin
					if (c > LIM_YEAR) c = LIM_YEAR;
					chip_regs[REG_YEAR] = bcd_of(32'(c));
				end
				FLD_HOUR: begin
					if (c > LIM_HOUR) c = LIM_HOUR;
					// afternoon hours fold to 1..11 with the PM bit
					if (c <= NOON) chip_regs[REG_HOUR] = (bcd_of(32'(c)) & 8'h1F) | HOUR_12H;
					else chip_regs[REG_HOUR] = (bcd_of(32'(c - NOON)) & 8'h1F) | HOUR_PM;
				end
				default: begin
					if (c > LIM_MINUTE) c = LIM_MINUTE;
					chip_regs[REG_MIN] = bcd_of(32'(c)) & 8'h7F;
				end
			endcase
			adj_cnt = c;
			chip_regs[REG_SEC] = '0;
		end

		blank = blink_on && set_active;
		if (set_active) begin
			date_view = field_sel < FLD_HOUR;
			r.am_led = date_view;
			r.pm_led = !date_view;
		end else begin
			date_view = ev.show_date;
			r.pm_led = chip_regs[REG_HOUR][5];
			r.am_led = !chip_regs[REG_HOUR][5];
		end
		if (date_view) begin
			r.digits = {
				digit_pair(chip_regs[REG_MONTH][3:0], {3'b0, chip_regs[REG_MONTH][4]},
					blank && field_sel == FLD_MONTH),
				digit_pair(chip_regs[REG_DAY][3:0], {2'b0, chip_regs[REG_DAY][5:4]},
					blank && field_sel == FLD_DAY),
				digit_pair(chip_regs[REG_YEAR][3:0], chip_regs[REG_YEAR][7:4],
					blank && field_sel == FLD_YEAR)};
		end else begin
			r.digits = {
				digit_pair(chip_regs[REG_HOUR][3:0], {3'b0, chip_regs[REG_HOUR][4]},
					blank && field_sel == FLD_HOUR),
				digit_pair(chip_regs[REG_MIN][3:0], {1'b0, chip_regs[REG_MIN][6:4]},
					blank && field_sel == FLD_MINUTE),
				digit_pair(chip_regs[REG_SEC][3:0], {1'b0, chip_regs[REG_SEC][6:4]}, 1'b0)};
		end
		r.intensity      = bright;
		r.commit         = leaving;
		r.commit_minutes = leaving ? chip_regs[REG_MIN] : '0;
		r.commit_hours   = leaving ? chip_regs[REG_HOUR] : '0;
		r.commit_day     = leaving ? chip_regs[REG_DAY] : '0;
		r.commit_month   = leaving ? chip_regs[REG_MONTH] : '0;
		r.commit_year    = leaving ? chip_regs[REG_YEAR] : '0;
		return r;
	endfunction

	// An event with random view and random (ignored unless refresh) bytes.
	function automatic clock_event_t make_event(logic [CMD_W-1:0] c);
		clock_event_t e;
		{e.show_date, e.seconds, e.minutes, e.hours, e.day, e.month, e.year} =
			49'({$urandom, $urandom});
		e.cmd = c;
		return e;
	endfunction

	// Refresh with raw bytes half the time, with plausible clock bytes otherwise.
	function automatic clock_event_t make_refresh();
		clock_event_t e;
		e = make_event(CMD_REFRESH);
		if ($urandom_range(0, 1)) begin
			e.seconds = bcd_of($urandom_range(0, 59));
			e.minutes = bcd_of($urandom_range(0, 59));
			e.hours   = bcd_of($urandom_range(1, 12)) | ($urandom_range(0, 1) ? HOUR_PM : HOUR_12H);
			e.day     = bcd_of($urandom_range(1, 31));
			e.month   = bcd_of($urandom_range(1, 12));
			e.year    = bcd_of($urandom_range(0, 99));
		end
		return e;
	endfunction

	function automatic logic [CMD_W-1:0] spare_cmd();
		return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
	endfunction

	task automatic enqueue(clock_event_t e);
		event_q.push_back(e);
		events_queued++;
	endtask

	// One adjust event inside a set field; climbing runs push the counter toward its clamp.
	task automatic queue_adjust(bit climbing);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < (climbing ? 85 : 45)) enqueue(make_event(CMD_INC));
		else if (roll < (climbing ? 90 : 85)) enqueue(make_event(CMD_DEC));
		else if (roll < 97) enqueue(make_event(CMD_TICK));
		else if (roll < 99) enqueue(make_refresh());
		else enqueue(make_event(spare_cmd()));
	endtask

	// Full pass through set mode: enter, adjust every field, leave and commit.
	task automatic queue_set_session();
		int f;
		int n;
		bit climbing;
		enqueue(make_event(CMD_MODE));
		for (f = 0; f < 5; f++) begin
			climbing = $urandom_range(0, 2) != 0;
			if (f == int'(FLD_YEAR) && $urandom_range(0, 3) == 0) begin
				// straight climb past 99 to hit the counter ceiling
				repeat ($urandom_range(100, 110)) enqueue(make_event(CMD_INC));
			end else begin
				n = $urandom_range(0, RUN_MAX[f]);
				repeat (n) queue_adjust(climbing);
			end
			enqueue(make_event(CMD_MODE));
		end
	endtask

	// Run-mode traffic: brightness ramps or a mix of ticks, refreshes and noise.
	task automatic queue_run_segment();
		int n;
		int roll;
		logic [CMD_W-1:0] ramp;
		if ($urandom_range(0, 3) == 0) begin
			ramp = $urandom_range(0, 1) ? CMD_INC : CMD_DEC;
			repeat (16) enqueue(make_event(ramp));
		end else begin
			n = $urandom_range(1, 15);
			repeat (n) begin
				roll = $urandom_range(0, 99);
				if (roll < 40) enqueue(make_event(CMD_TICK));
				else if (roll < 55) enqueue(make_event(CMD_INC));
				else if (roll < 70) enqueue(make_event(CMD_DEC));
				else if (roll < 95) enqueue(make_refresh());
				else enqueue(make_event(spare_cmd()));
			end
		end
	endtask

	task automatic random_phase(int count);
		int stop_at;
		stop_at = events_queued + count;
		while (events_queued < stop_at) begin
			if ($urandom_range(0, 9) < 5) queue_set_session();
			else queue_run_segment();
		end
	endtask

	// Hold until every queued event has been taken and every display checked.
	task automatic wait_idle();
		do @(negedge clk);
		while (event_q.size() != 0 || in_valid || predicted_q.size() != 0);
	endtask

	// One register write; the image follows at the edge the block latches it.
	task automatic write_reg(cfg_idx_t idx, logic [BYTE_W-1:0] value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == CFG_BLINK_LIMIT) blink_limit_r = value;
		else bright = (value[3:0] > MAX_BRIGHT) ? MAX_BRIGHT : value[3:0];
		config_writes++;
	endtask

	task automatic check_field(string what, logic [DIGITS_W-1:0] want, logic [DIGITS_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// Driver: present events in bursts of random length with random gaps.
	// Hold the beat until it is taken; predict its display at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_q.push_back(advance_clock(on_wire));
				events_taken++;
			end
			if (!in_valid || in_ready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (gap_left > 0 || event_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					on_wire = event_q.pop_front();
					burst_left--;
					in_valid     <= 1'b1;
					cmd          <= on_wire.cmd;
					show_date    <= on_wire.show_date;
					rtc_seconds  <= on_wire.seconds;
					rtc_minutes  <= on_wire.minutes;
					rtc_hours    <= on_wire.hours;
					rtc_day      <= on_wire.day;
					rtc_month_in <= on_wire.month;
					rtc_year_in  <= on_wire.year;
				end
			end
		end
	end

	// Monitor: check each display beat against the oldest prediction.
	// Drive ready on a rotating stall pattern; every so often drop it for a long
	// stretch so the result register fills and the block stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: display beat with nothing expected, digits %06h",
							$time, digits);
				end else begin
					result_t want;
					want = predicted_q.pop_front();
					check_field("digits", want.digits, digits);
					check_field("am_led", DIGITS_W'(want.am_led), DIGITS_W'(am_led));
					check_field("pm_led", DIGITS_W'(want.pm_led), DIGITS_W'(pm_led));
					check_field("intensity", DIGITS_W'(want.intensity), DIGITS_W'(intensity));
					check_field("commit", DIGITS_W'(want.commit), DIGITS_W'(commit));
					check_field("commit_minutes", DIGITS_W'(want.commit_minutes),
						DIGITS_W'(commit_minutes));
					check_field("commit_hours", DIGITS_W'(want.commit_hours),
						DIGITS_W'(commit_hours));
					check_field("commit_day", DIGITS_W'(want.commit_day),
						DIGITS_W'(commit_day));
					check_field("commit_month", DIGITS_W'(want.commit_month),
						DIGITS_W'(commit_month));
					check_field("commit_year", DIGITS_W'(want.commit_year),
						DIGITS_W'(commit_year));
					if (want.commit) commits_seen++;
				end
				displays_seen++;
			end
			rx_cycle <= rx_cycle + 32'd1;
			if (displays_seen >= next_holdoff) begin
				next_holdoff = next_holdoff + HOLDOFF_EVERY;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_cycle[7:6])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= 1'($urandom_range(0, 1));
					2'd2: out_ready <= $urandom_range(0, 4) != 0;
					default: out_ready <= rx_cycle[1:0] != 2'd0;
				endcase
			end
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long.
	initial begin
		int stalled;
		stalled = 0;
		@(posedge arst_n);
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
			else stalled++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Stimulus: directed events, then random phases under several register settings.
	initial begin
		clock_event_t e;
		int p;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: views of reset bytes, all-ones and all-zero bytes,
		// a PM hour, brightness steps and the unused command codes.
		enqueue(make_event(CMD_TICK));
		e = make_event(CMD_REFRESH);
		{e.seconds, e.minutes, e.hours, e.day, e.month, e.year} = '1;
		e.show_date = 1'b0;
		enqueue(e);
		e = make_event(CMD_TICK);
		e.show_date = 1'b1;
		enqueue(e);
		e = make_event(CMD_REFRESH);
		{e.seconds, e.minutes, e.hours, e.day, e.month, e.year} = '0;
		e.show_date = 1'b1;
		enqueue(e);
		e = make_event(CMD_REFRESH);
		e.show_date = 1'b0;
		e.seconds = 8'h59;
		e.minutes = 8'h59;
		e.hours   = HOUR_PM | 8'h11;
		e.day     = 8'h31;
		e.month   = 8'h12;
		e.year    = 8'h99;
		enqueue(e);
		enqueue(make_event(CMD_INC));
		enqueue(make_event(CMD_DEC));
		enqueue(make_event(CMD_SPARE_FIRST));
		enqueue(make_event(CMD_SPARE_MID));
		enqueue(make_event(CMD_SPARE_LAST));

		// Blink on every tick, start brightness above the maximum.
		wait_idle();
		write_reg(CFG_BLINK_LIMIT, 8'd0);
		write_reg(CFG_INTENSITY_START, 8'd15);

		// Brightness clamp at the top, then a pass through set mode with the
		// blinking field, a refresh that set mode ignores, a counter floored at
		// zero, and the commit on the way out.
		enqueue(make_event(CMD_INC));
		enqueue(make_event(CMD_TICK));
		enqueue(make_event(CMD_MODE));
		enqueue(make_event(CMD_DEC));
		enqueue(make_refresh());
		enqueue(make_event(CMD_TICK));
		enqueue(make_event(CMD_INC));
		enqueue(make_event(CMD_MODE));
		enqueue(make_event(CMD_MODE));
		enqueue(make_event(CMD_TICK));
		enqueue(make_event(CMD_MODE));
		enqueue(make_event(CMD_MODE));
		enqueue(make_event(CMD_TICK));
		enqueue(make_event(CMD_MODE));

		for (p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_reg(CFG_BLINK_LIMIT, PHASE_LIMIT[p]);
			write_reg(CFG_INTENSITY_START, PHASE_START[p]);
			random_phase(PHASE_EVENTS);
		end

		// Drain, then keep clocking to expose any stray beat.
		wait_idle();
		repeat (4) @(negedge clk);

		$display("Drove %0d events through set passes, refreshes and brightness ramps",
			events_taken);
		$display("under %0d register writes; checked %0d displays, %0d commits.",
			config_writes, displays_seen, commits_seen);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/cscd_pkg.sv
sv/cscd_core.sv
sv/cscd_view.sv
sv/clock_set_display_controller.sv
dv/clock_set_display_controller_tb.sv
